// ===== design/bb3_pkg.sv =====
// bb3_pkg: shared constants, types and register codes for the 3x3 RGB box blur.
// Used by bb3_front, bb3_queue, bb3_back and box_blur_3x3_rgb. No dependencies.
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CFG_W  = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);

  localparam int WORD_W = 32;
  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;
  localparam int CSUM_W = 10;
  localparam int SUM_W  = 12;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 2);

  localparam int DIV9_MUL   = 7282;
  localparam int DIV9_SHIFT = 16;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

  typedef struct packed {
    logic [W_W-1:0]   w;
    logic [ROW_W-1:0] h;
    logic             restart;
  } dims_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
    logic             last;
  } sum_t;

endpackage

// ===== design/box_blur_3x3_rgb.sv =====
// box_blur_3x3_rgb: top level of the 3x3 RGB box blur; config registers and APB port.
// Depends on bb3_pkg, bb3_front, bb3_queue, bb3_back.
//
//   channel   ports                                      handshake
//   input     in_req_type, in_pixel_word                 push / full
//   result    out_red/green/blue, out_frame_last         pop / empty
//   config    psel penable pwrite paddr pwdata prdata    pready (tied high)
//
// One word per cycle sustained while full stays low. A result reaches the output
// after the line-store read and window sum in stage B, the sum queue, and the
// divide at the output register. full rises when the 4-word sum queue plus the
// word in the window stage would fill it. Line stores need no clearing pass:
// reset only clears counters and valid bits. A config write restarts the frame.
module box_blur_3x3_rgb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_req_type,
  input  logic [31:0] in_pixel_word,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CFG_W  = bb3_pkg::CFG_W;
  localparam int W_W    = bb3_pkg::W_W;
  localparam int ROW_W  = bb3_pkg::ROW_W;
  localparam int DATA_W = bb3_pkg::DATA_W;

  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic             cfg_wr;
  logic [0:0]       cfg_idx;

  bb3_pkg::dims_t               dims;
  bb3_pkg::sum_t                q_wdata, q_rdata;
  logic                         q_wr, q_rd, q_not_empty;
  logic [bb3_pkg::QCNT_W-1:0]   q_count;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[2];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        bb3_pkg::REG_FRAME_WIDTH:  width_nxt  = pwdata[CFG_W-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: height_nxt = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bb3_pkg::RESET_WIDTH;
      height_r <= bb3_pkg::RESET_HEIGHT;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bb3_pkg::REG_FRAME_WIDTH:  prdata = DATA_W'(width_r);
      bb3_pkg::REG_FRAME_HEIGHT: prdata = DATA_W'(height_r);
      default:                   prdata = '0;
    endcase
  end

  // zero reads as one, oversize clamps to MAX_WIDTH (the store depth) or MAX_HEIGHT
  always_comb begin
    if (width_r == '0) begin
      dims.w = W_W'(1);
    end else if (int'(width_r) > bb3_pkg::MAX_WIDTH) begin
      dims.w = W_W'(bb3_pkg::MAX_WIDTH);
    end else begin
      dims.w = W_W'(width_r);
    end
    if (height_r == '0) begin
      dims.h = ROW_W'(1);
    end else if (int'(height_r) > bb3_pkg::MAX_HEIGHT) begin
      dims.h = ROW_W'(bb3_pkg::MAX_HEIGHT);
    end else begin
      dims.h = ROW_W'(height_r);
    end
    dims.restart = cfg_wr;
  end

  bb3_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .dims          (dims),
    .push          (push),
    .in_req_type   (in_req_type),
    .in_pixel_word (in_pixel_word),
    .full          (full),
    .q_count       (q_count),
    .q_wr          (q_wr),
    .q_data        (q_wdata)
  );

  bb3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (q_wr),
    .wdata     (q_wdata),
    .rd        (q_rd),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  bb3_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_rdata        (q_rdata),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_frame_last (out_frame_last)
  );

endmodule

// ===== design/bb3_queue.sv =====
// bb3_queue: short word queue between the front (window sums) and back (divide).
// Depends on bb3_pkg (depth, sum_t).
module bb3_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr,
  input  bb3_pkg::sum_t              wdata,
  input  logic                       rd,
  output bb3_pkg::sum_t              rdata,
  output logic                       not_empty,
  output logic [bb3_pkg::QCNT_W-1:0] count
);

  localparam int QPTR_W = bb3_pkg::QPTR_W;
  localparam int QCNT_W = bb3_pkg::QCNT_W;

  bb3_pkg::sum_t     entry_r [bb3_pkg::QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (wr) begin
      wptr_nxt = (wptr_r == QPTR_W'(bb3_pkg::QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
    end
    if (rd) begin
      rptr_nxt = (rptr_r == QPTR_W'(bb3_pkg::QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
    end
    if (wr && !rd) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (rd && !wr) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entry_r[wptr_r] <= wdata;
    end
  end

  assign rdata     = entry_r[rptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && !rd && count_r == QCNT_W'(bb3_pkg::QDEPTH)))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd && count_r == '0))
    else $error("queue read while empty");
`endif

endmodule

// ===== design/bb3_front.sv =====
// bb3_front: accepts pixel/drain words, keeps line stores, frame counters and window,
// and emits masked 3x3 channel sums into the queue. Depends on bb3_pkg.
module bb3_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bb3_pkg::dims_t             dims,
  input  logic                       push,
  input  logic                       in_req_type,
  input  logic [31:0]                in_pixel_word,
  output logic                       full,
  input  logic [bb3_pkg::QCNT_W-1:0] q_count,
  output logic                       q_wr,
  output bb3_pkg::sum_t              q_data
);

  localparam int COL_W  = bb3_pkg::COL_W;
  localparam int W_W    = bb3_pkg::W_W;
  localparam int ROW_W  = bb3_pkg::ROW_W;
  localparam int OROW_W = bb3_pkg::OROW_W;
  localparam int PEND_W = bb3_pkg::PEND_W;
  localparam int PIX_W  = bb3_pkg::PIX_W;
  localparam int CH_W   = bb3_pkg::CH_W;
  localparam int CSUM_W = bb3_pkg::CSUM_W;
  localparam int SUM_W  = bb3_pkg::SUM_W;
  localparam int QCNT_W = bb3_pkg::QCNT_W;

  typedef struct packed {
    logic [CSUM_W-1:0] r;
    logic [CSUM_W-1:0] g;
    logic [CSUM_W-1:0] b;
  } col_t;

  logic [PIX_W-1:0] upper_mem  [bb3_pkg::MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [bb3_pkg::MAX_WIDTH];

  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  logic              b_push_r, b_emit_r;
  logic              b_last_r, b_fwd_r;
  logic              b_top_m_r, b_bot_m_r, b_lm_r, b_rm_r;
  logic [COL_W-1:0]  b_ix_r;
  logic [PIX_W-1:0]  b_px_r;
  logic [PIX_W-1:0]  up_rd_r, mid_rd_r, fwd_mid_r;
  col_t              win_r [2];

  logic              accept, in_done, acc_push, early, acc_emit, acc_last;
  logic              in_col_end, out_col_end, out_row_end;
  logic [PIX_W-1:0]  px;
  logic [PIX_W-1:0]  up_eff, up_m, px_m;
  logic [QCNT_W-1:0] occ;
  col_t              cs, left_c, right_c;

  // inflight emit in stage B is counted so the queue never overflows
  assign occ  = q_count + QCNT_W'(b_emit_r);
  assign full = (occ >= QCNT_W'(bb3_pkg::QDEPTH));

  assign accept      = push && !full;
  assign in_done     = (in_row_r >= dims.h);
  assign acc_push    = accept && (in_req_type ? (in_done && pend_r != '0) : !in_done);
  assign early       = (in_row_r == '0) || (in_row_r == ROW_W'(1) && in_col_r == '0);
  assign acc_emit    = acc_push && !early;
  assign in_col_end  = ((W_W'(in_col_r) + W_W'(1)) >= dims.w);
  assign out_col_end = ((W_W'(out_col_r) + W_W'(1)) >= dims.w);
  assign out_row_end = ((ROW_W'(out_row_r) + ROW_W'(1)) >= dims.h);
  assign acc_last    = acc_emit && out_col_end && out_row_end;
  assign px          = in_req_type ? '0 : in_pixel_word[31:8];

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pend_nxt    = pend_r + PEND_W'(acc_push && !in_req_type) - PEND_W'(acc_emit);
    if (acc_push) begin
      if (in_col_end) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end
    if (acc_emit) begin
      if (out_col_end) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + OROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end
    if (acc_last || dims.restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      pend_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
      b_push_r  <= 1'b0;
      b_emit_r  <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
      b_push_r  <= acc_push;
      b_emit_r  <= acc_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_push) begin
      b_last_r  <= acc_last;
      b_ix_r    <= in_col_r;
      b_px_r    <= px;
      b_top_m_r <= (in_row_r == ROW_W'(1));
      b_bot_m_r <= in_done;
      b_lm_r    <= (out_col_r == '0);
      b_rm_r    <= out_col_end;
      b_fwd_r   <= b_push_r && (b_ix_r == in_col_r);
    end
  end

  // middle store: read old entry, write new pixel
  always_ff @(posedge clk) begin
    if (acc_push) begin
      mid_rd_r             <= middle_mem[in_col_r];
      middle_mem[in_col_r] <= px;
    end
  end

  // upper store: read at accept, write back old middle in the next cycle
  always_ff @(posedge clk) begin
    if (acc_push) begin
      up_rd_r <= upper_mem[in_col_r];
    end
    if (b_push_r) begin
      upper_mem[b_ix_r] <= mid_rd_r;
    end
  end

  // same-entry write/read in back-to-back words (one-pixel rows)
  assign up_eff = b_fwd_r ? fwd_mid_r : up_rd_r;
  assign up_m   = b_top_m_r ? '0 : up_eff;
  assign px_m   = b_bot_m_r ? '0 : b_px_r;

  always_comb begin
    cs.r = CSUM_W'(up_m[CH_W-1:0]) + CSUM_W'(mid_rd_r[CH_W-1:0])
         + CSUM_W'(px_m[CH_W-1:0]);
    cs.g = CSUM_W'(up_m[2*CH_W-1:CH_W]) + CSUM_W'(mid_rd_r[2*CH_W-1:CH_W])
         + CSUM_W'(px_m[2*CH_W-1:CH_W]);
    cs.b = CSUM_W'(up_m[3*CH_W-1:2*CH_W]) + CSUM_W'(mid_rd_r[3*CH_W-1:2*CH_W])
         + CSUM_W'(px_m[3*CH_W-1:2*CH_W]);
  end

  assign left_c  = b_lm_r ? '0 : win_r[0];
  assign right_c = b_rm_r ? '0 : cs;

  always_ff @(posedge clk) begin
    if (b_push_r) begin
      fwd_mid_r <= mid_rd_r;
      win_r[0]  <= win_r[1];
      win_r[1]  <= cs;
    end
  end

  assign q_wr        = b_emit_r;
  assign q_data.r    = SUM_W'(left_c.r) + SUM_W'(win_r[1].r) + SUM_W'(right_c.r);
  assign q_data.g    = SUM_W'(left_c.g) + SUM_W'(win_r[1].g) + SUM_W'(right_c.g);
  assign q_data.b    = SUM_W'(left_c.b) + SUM_W'(win_r[1].b) + SUM_W'(right_c.b);
  assign q_data.last = b_last_r;

`ifndef SYNTH
  a_emit_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    b_emit_r |-> b_push_r)
    else $error("emit without column push");
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(bb3_pkg::MAX_WIDTH + 1))
    else $error("pending count out of range");
`endif

endmodule

// ===== design/bb3_back.sv =====
// bb3_back: divides queued window sums by 9 and holds the result word for the consumer.
// Depends on bb3_pkg (sum_t, divide constants).
module bb3_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  bb3_pkg::sum_t      q_rdata,
  output logic               q_rd,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_frame_last
);

  localparam int SUM_W  = bb3_pkg::SUM_W;
  localparam int CH_W   = bb3_pkg::CH_W;
  localparam int PROD_W = SUM_W + 13;

  // floor(x / 9) for x <= 9 * 255 by reciprocal multiply
  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(bb3_pkg::DIV9_MUL);
    return prod[bb3_pkg::DIV9_SHIFT +: CH_W];
  endfunction

  logic ov_r, ov_nxt;
  logic load;

  assign load   = q_not_empty && (!ov_r || pop);
  assign ov_nxt = load || (ov_r && !pop);
  assign q_rd   = load;
  assign empty  = !ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_red        <= div9(q_rdata.r);
      out_green      <= div9(q_rdata.g);
      out_blue       <= div9(q_rdata.b);
      out_frame_last <= q_rdata.last;
    end
  end

endmodule
